// ----- sv/pitch_drift_lfo_macros.svh -----
// ---------------------------------------------------------------------------
// Pitch drift LFO assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef PITCH_DRIFT_LFO_MACROS_SVH
`define PITCH_DRIFT_LFO_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PDL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PDL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- sv/pdlfo_pkg.sv -----
// ---------------------------------------------------------------------------
// Pitch drift LFO package
// Codes, control word layout and the sequencer program.
// ---------------------------------------------------------------------------
package pdlfo_pkg;

  localparam logic [1:0] PAT_SINE   = 2'd0;
  localparam logic [1:0] PAT_HOLD   = 2'd1;
  localparam logic [1:0] PAT_SUM    = 2'd2;
  localparam logic [1:0] PAT_SILENT = 2'd3;

  localparam logic [2:0] CFG_PATTERN      = 3'd0;
  localparam logic [2:0] CFG_AMOUNT       = 3'd1;
  localparam logic [2:0] CFG_PHASE_STEP   = 3'd2;
  localparam logic [2:0] CFG_HOLD_SAMPLES = 3'd3;
  localparam logic [2:0] CFG_NOISE_SEED   = 3'd4;

  localparam logic [1:0]  PATTERN_RESET      = PAT_SUM;
  localparam logic [12:0] AMOUNT_RESET       = 13'd328;
  localparam logic [23:0] PHASE_STEP_RESET   = 24'd44739;
  localparam logic [15:0] HOLD_SAMPLES_RESET = 16'd4800;
  localparam logic [31:0] NOISE_SEED_RESET   = 32'd1;

  localparam logic [12:0] AMOUNT_MAX  = 13'd6554;
  localparam logic [17:0] K_SECOND    = 18'd92471;
  localparam logic [17:0] K_THIRD     = 18'd191431;
  localparam logic [31:0] LFSR_TAPS   = 32'hD000_0001;
  localparam logic [22:0] UNITY_Q22   = 23'd4194304;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_SINE     = 4'd1;
  localparam logic [PC_W-1:0] PC_SINE_OUT = 4'd2;
  localparam logic [PC_W-1:0] PC_HOLD     = 4'd3;
  localparam logic [PC_W-1:0] PC_HOLD_OUT = 4'd4;
  localparam logic [PC_W-1:0] PC_SUM_A    = 4'd5;
  localparam logic [PC_W-1:0] PC_SUM_B    = 4'd6;
  localparam logic [PC_W-1:0] PC_SUM_C    = 4'd7;
  localparam logic [PC_W-1:0] PC_SUM_D    = 4'd8;
  localparam logic [PC_W-1:0] PC_DIV_A    = 4'd9;
  localparam logic [PC_W-1:0] PC_DIV_B    = 4'd10;
  localparam logic [PC_W-1:0] PC_SUM_OUT  = 4'd11;
  localparam logic [PC_W-1:0] PC_SILENT   = 4'd12;
  localparam logic [PC_W-1:0] PC_SCALE    = 4'd13;
  localparam logic [PC_W-1:0] PC_FINISH   = 4'd14;

  typedef enum logic [1:0] {SEL_MAIN, SEL_SECOND, SEL_THIRD} sine_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {KM_NONE, KM_SECOND, KM_THIRD} kmul_t;
  typedef enum logic [1:0] {PH_NONE, PH_MAIN, PH_SECOND, PH_THIRD} ph_op_t;
  typedef enum logic [2:0] {DS_KEEP, DS_SINE, DS_QUOT, DS_HELD, DS_ZERO} drift_src_t;
  typedef enum logic [1:0] {J_NEXT, J_ALWAYS, J_ACCEPT, J_OUT_FREE} jump_t;

  typedef struct packed {
    logic             sine_load;
    sine_sel_t        sine_sel;
    acc_op_t          acc_op;
    logic [1:0]       acc_shift;
    kmul_t            kmul;
    ph_op_t           ph_op;
    logic             hold_tick;
    logic             div_mul;
    logic             div_fix;
    drift_src_t       drift_src;
    logic             amt_mul;
    logic             out_load;
    jump_t            jump;
    logic [PC_W-1:0]  target;
  } ucode_t;

  function automatic logic [PC_W-1:0] pattern_entry(input logic [1:0] pat);
    logic [PC_W-1:0] entry;
    case (pat)
      PAT_SINE: entry = PC_SINE;
      PAT_HOLD: entry = PC_HOLD;
      PAT_SUM:  entry = PC_SUM_A;
      default:  entry = PC_SILENT;
    endcase
    return entry;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    uw = '0;
    case (pc)
      PC_IDLE: begin
        uw.jump = J_ACCEPT;
      end
      PC_SINE: begin
        uw.sine_load = 1'b1;
        uw.sine_sel  = SEL_MAIN;
        uw.ph_op     = PH_MAIN;
      end
      PC_SINE_OUT: begin
        uw.drift_src = DS_SINE;
        uw.jump      = J_ALWAYS;
        uw.target    = PC_SCALE;
      end
      PC_HOLD: begin
        uw.hold_tick = 1'b1;
      end
      PC_HOLD_OUT: begin
        uw.drift_src = DS_HELD;
        uw.jump      = J_ALWAYS;
        uw.target    = PC_SCALE;
      end
      PC_SUM_A: begin
        uw.sine_load = 1'b1;
        uw.sine_sel  = SEL_MAIN;
        uw.ph_op     = PH_MAIN;
        uw.kmul      = KM_SECOND;
      end
      PC_SUM_B: begin
        uw.sine_load = 1'b1;
        uw.sine_sel  = SEL_SECOND;
        uw.acc_op    = ACC_LOAD;
        uw.acc_shift = 2'd2;
        uw.ph_op     = PH_SECOND;
        uw.kmul      = KM_THIRD;
      end
      PC_SUM_C: begin
        uw.sine_load = 1'b1;
        uw.sine_sel  = SEL_THIRD;
        uw.acc_op    = ACC_ADD;
        uw.acc_shift = 2'd1;
        uw.ph_op     = PH_THIRD;
      end
      PC_SUM_D: begin
        uw.acc_op    = ACC_ADD;
        uw.acc_shift = 2'd0;
      end
      PC_DIV_A: begin
        uw.div_mul = 1'b1;
      end
      PC_DIV_B: begin
        uw.div_fix = 1'b1;
      end
      PC_SUM_OUT: begin
        uw.drift_src = DS_QUOT;
        uw.jump      = J_ALWAYS;
        uw.target    = PC_SCALE;
      end
      PC_SILENT: begin
        uw.drift_src = DS_ZERO;
      end
      PC_SCALE: begin
        uw.amt_mul = 1'b1;
      end
      PC_FINISH: begin
        uw.out_load = 1'b1;
        uw.jump     = J_OUT_FREE;
        uw.target   = PC_IDLE;
      end
      default: begin
        uw.jump   = J_ALWAYS;
        uw.target = PC_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

// ----- sv/pitch_drift_lfo.sv -----
// ---------------------------------------------------------------------------
// Pitch drift LFO
// Per-sample detune multiplier from sine, sample-and-hold noise, summed sines
// or no drift, run by a small microcoded sequencer over a shared datapath.
// ---------------------------------------------------------------------------
// One result per accepted item. The sequencer takes an item only at step
// zero and returns there once the result is in the output register. Summed
// sines take the most steps, since the one sine table read serves each of
// the three phases in turn and the one phase multiplier each of the two
// upper phases. A result left waiting at the output holds the sequencer in
// its final step. Configuration is taken at any time but is meant to be
// written while no item is in flight.
`include "pitch_drift_lfo_macros.svh"

module pitch_drift_lfo #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [22:0]        multiplier,
  output logic signed [15:0] drift,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pdlfo_pkg::*;

  localparam int QSIZE     = 1 << (SINE_ADDR_BITS - 2);
  localparam int STEP_SHL  = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int STEP_SHR  = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int STEP_W    = 24 + STEP_SHL + PHASE_BITS;
  localparam int KP_W      = 42;
  localparam int INC_W     = (KP_W + STEP_SHL + 1 > PHASE_BITS + 17) ?
                             KP_W + STEP_SHL + 1 : PHASE_BITS + 17;
  localparam int SUM_W     = SAMPLE_BITS + 3;
  localparam int A_W       = SAMPLE_BITS + 2;
  localparam logic [A_W-1:0] DIV_M = A_W'((64'd1 << A_W) / 7);
  localparam int Q15_SHR   = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
  localparam int Q15_SHL   = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int TQ_W      = SAMPLE_BITS + 1 + Q15_SHL;
  localparam logic [63:0] SMAX64 = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  function automatic logic [63:0] sine_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    x  = (64'(i) * HALF_PI_Q30) >> (SINE_ADDR_BITS - 2);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    e  = (s * SMAX64 + (ONE_Q30 >> 1)) >> 30;
    if (e > SMAX64) begin
      e = SMAX64;
    end
    return e;
  endfunction

  logic [SAMPLE_BITS-2:0] sine_rom [QSIZE+1];

  for (genvar g = 0; g <= QSIZE; g++) begin : g_sine
    localparam logic [SAMPLE_BITS-2:0] ENTRY = (SAMPLE_BITS-1)'(sine_entry(g));
    assign sine_rom[g] = ENTRY;
  end

  // configuration
  logic [1:0]  pattern;
  logic [12:0] amount;
  logic [23:0] phase_step;
  logic [15:0] hold_samples;
  logic [31:0] noise_seed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern      <= PATTERN_RESET;
      amount       <= AMOUNT_RESET;
      phase_step   <= PHASE_STEP_RESET;
      hold_samples <= HOLD_SAMPLES_RESET;
      noise_seed   <= NOISE_SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN:      pattern      <= cfg_data[1:0];
        CFG_AMOUNT:       amount       <= (cfg_data[12:0] > AMOUNT_MAX) ?
                                          AMOUNT_MAX : cfg_data[12:0];
        CFG_PHASE_STEP:   phase_step   <= cfg_data[23:0];
        CFG_HOLD_SAMPLES: hold_samples <= cfg_data[15:0];
        CFG_NOISE_SEED:   noise_seed   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          uw;
  logic            accept;
  logic            out_free;

  assign uw       = ucode_rom(pc);
  assign in_stall = (pc != PC_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (uw.jump)
      J_NEXT:     pc_next = pc + PC_W'(1);
      J_ALWAYS:   pc_next = uw.target;
      J_ACCEPT:   pc_next = accept ? pattern_entry(pattern) : pc;
      J_OUT_FREE: pc_next = out_free ? uw.target : pc;
      default:    pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // phase datapath
  logic [PHASE_BITS-1:0] main_phase;
  logic [PHASE_BITS-1:0] second_phase;
  logic [PHASE_BITS-1:0] third_phase;
  logic [23:0]           step_core;
  logic [STEP_W-1:0]     step_wide;
  logic [PHASE_BITS-1:0] step;
  logic [KP_W-1:0]       kprod;
  logic [17:0]           kconst;
  logic [INC_W-1:0]      inc_wide;
  logic [PHASE_BITS-1:0] inc;

  assign step_core = phase_step >> STEP_SHR;
  assign step_wide = STEP_W'(step_core) << STEP_SHL;
  assign step      = step_wide[PHASE_BITS-1:0];
  assign kconst    = (uw.kmul == KM_THIRD) ? K_THIRD : K_SECOND;
  assign inc_wide  = ((INC_W'(kprod) << STEP_SHL) + INC_W'(32768)) >> 16;
  assign inc       = inc_wide[PHASE_BITS-1:0];

  // sine lookup
  logic [PHASE_BITS-1:0]     sel_phase;
  logic [SINE_ADDR_BITS-1:0] sidx;
  logic [SINE_ADDR_BITS-2:0] roff;
  logic [SAMPLE_BITS-2:0]    rval;
  logic signed [SAMPLE_BITS-1:0] sine_q;
  logic signed [SAMPLE_BITS-1:0] sine_c;

  always_comb begin
    case (uw.sine_sel)
      SEL_SECOND: sel_phase = second_phase;
      SEL_THIRD:  sel_phase = third_phase;
      default:    sel_phase = main_phase;
    endcase
  end

  assign sidx   = sel_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign roff   = sidx[SINE_ADDR_BITS-2] ?
                  (SINE_ADDR_BITS-1)'(QSIZE) - {1'b0, sidx[SINE_ADDR_BITS-3:0]} :
                  {1'b0, sidx[SINE_ADDR_BITS-3:0]};
  assign rval   = sine_rom[roff];
  assign sine_c = sidx[SINE_ADDR_BITS-1] ? -$signed({1'b0, rval}) : $signed({1'b0, rval});

  // noise
  logic [31:0]        noise_lfsr;
  logic [15:0]        hold_count;
  logic signed [15:0] held_value;
  logic [16:0]        hold_next;
  logic [31:0]        lfsr_step;
  logic [31:0]        seed_load;
  logic signed [15:0] noise_val;

  assign hold_next = {1'b0, hold_count} + 17'd1;
  assign lfsr_step = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? LFSR_TAPS : 32'd0);
  assign seed_load = (noise_seed == 32'd0) ? 32'd1 : noise_seed;
  assign noise_val = (lfsr_step[31:16] == 16'd0) ? -16'sd32767 :
                     $signed({~lfsr_step[31], lfsr_step[30:16]});

  // sum and divide by seven
  logic signed [SUM_W-1:0]       acc;
  logic signed [SUM_W-1:0]       acc_term;
  logic [SUM_W-1:0]              acc_abs;
  logic [A_W-1:0]                mag;
  logic                          neg;
  logic [2*A_W-1:0]              dprod;
  logic [A_W-1:0]                q0;
  logic [A_W-1:0]                rem;
  logic [A_W-1:0]                qf;
  logic signed [SAMPLE_BITS-1:0] qs;
  logic signed [SAMPLE_BITS-1:0] quot;

  assign acc_term = SUM_W'(sine_q) <<< uw.acc_shift;
  assign acc_abs  = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
  assign q0       = dprod[2*A_W-1:A_W];
  assign rem      = A_W'({3'b000, mag} - {q0, 3'b000} + {3'b000, q0});
  assign qf       = q0 + ((rem >= A_W'(7)) ? A_W'(1) : A_W'(0));
  assign qs       = SAMPLE_BITS'(qf);

  // drift scaling
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [TQ_W-1:0]        tq;
  logic signed [TQ_W-1:0]        tq_bias;
  logic signed [TQ_W-1:0]        tq_res;
  logic signed [15:0]            samp_q15;
  logic signed [15:0]            drift_val;
  logic signed [29:0]            aprod;
  logic signed [30:0]            rnd;

  assign samp     = (uw.drift_src == DS_QUOT) ? quot : sine_q;
  assign tq       = TQ_W'(samp);
  assign tq_bias  = tq[TQ_W-1] ? TQ_W'((1 << Q15_SHR) - 1) : TQ_W'(0);
  assign tq_res   = ((tq + tq_bias) >>> Q15_SHR) <<< Q15_SHL;
  assign samp_q15 = 16'(tq_res);
  assign rnd      = 31'(aprod) + 31'sd256;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase   <= '0;
      second_phase <= '0;
      third_phase  <= '0;
      hold_count   <= '0;
      held_value   <= '0;
      noise_lfsr   <= NOISE_SEED_RESET;
    end else begin
      if (accept && restart) begin
        main_phase   <= '0;
        second_phase <= '0;
        third_phase  <= '0;
        hold_count   <= '0;
        held_value   <= '0;
        noise_lfsr   <= seed_load;
      end
      case (uw.ph_op)
        PH_MAIN:   main_phase   <= main_phase + step;
        PH_SECOND: second_phase <= second_phase + inc;
        PH_THIRD:  third_phase  <= third_phase + inc;
        default: ;
      endcase
      if (uw.hold_tick) begin
        if (hold_next >= {1'b0, hold_samples}) begin
          noise_lfsr <= lfsr_step;
          held_value <= noise_val;
          hold_count <= '0;
        end else begin
          hold_count <= hold_next[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uw.sine_load) begin
      sine_q <= sine_c;
    end
    if (uw.kmul != KM_NONE) begin
      kprod <= KP_W'(step_core) * KP_W'(kconst);
    end
    case (uw.acc_op)
      ACC_LOAD: acc <= acc_term;
      ACC_ADD:  acc <= acc + acc_term;
      default: ;
    endcase
    if (uw.div_mul) begin
      mag   <= acc_abs[A_W-1:0];
      neg   <= acc[SUM_W-1];
      dprod <= (2*A_W)'(acc_abs[A_W-1:0]) * (2*A_W)'(DIV_M);
    end
    if (uw.div_fix) begin
      quot <= neg ? -qs : qs;
    end
    case (uw.drift_src)
      DS_SINE, DS_QUOT: drift_val <= samp_q15;
      DS_HELD:          drift_val <= held_value;
      DS_ZERO:          drift_val <= '0;
      default: ;
    endcase
    if (uw.amt_mul) begin
      aprod <= 30'($signed({1'b0, amount})) * 30'(drift_val);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.out_load && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.out_load && out_free) begin
      multiplier <= UNITY_Q22 + 23'(rnd >>> 9);
      drift      <= drift_val;
    end
  end

  `PDL_ASSERT_IMPLY(a_load_at_finish, clk, rst, $rose(out_valid), $past(pc) == PC_FINISH, "result loaded outside finish step")
  `PDL_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && !in_stall, pc != PC_IDLE, "accepted item did not start program")
  `PDL_ASSERT_NEXT(a_finish_holds, clk, rst, pc == PC_FINISH && out_valid && out_stall, pc == PC_FINISH, "finish step left while output blocked")
  `PDL_ASSERT_IMPLY(a_drift_bound, clk, rst, out_valid, drift != 16'sh8000, "drift at negative full scale")
  `PDL_ASSERT_IMPLY(a_mult_range, clk, rst, out_valid, multiplier >= 23'd3774861 && multiplier <= 23'd4613747, "multiplier out of range")

endmodule
